// ===== rtl/core/sfr_pkg.sv =====
package sfr_pkg;

  // widest pattern, replacement or burst of results in bytes
  localparam int EMAX = 8;
  // counts run from 0 to EMAX
  localparam int CNT_W = 4;
  // byte positions inside a burst
  localparam int IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SEARCH_LEN    = 2'd0,
    CFG_SEARCH_BYTES  = 2'd1,
    CFG_REPLACE_LEN   = 2'd2,
    CFG_REPLACE_BYTES = 2'd3
  } sfr_cfg_idx_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             load;
    logic             eval;
    logic             emit;
    logic             emit_last;
    logic [IDX_W-1:0] idx;
  } sfr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [CNT_W-1:0] eval_total;
    logic             slot_free;
  } sfr_status_t;

endpackage

// ===== rtl/core/sfr_ctrl.sv =====
module sfr_ctrl import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sfr_status_t st,
  output sfr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] tot;

  // command decode
  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.load      = in_ready && in_valid;
    cmd.eval      = (state == S_EVAL);
    cmd.emit      = (state == S_EMIT) && st.slot_free;
    cmd.emit_last = ((idx + 4'd1) == tot);
    cmd.idx       = idx[IDX_W-1:0];
  end

  // sequencer: take a request, evaluate it, then hand out its results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      tot   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) state <= S_EVAL;
        end
        S_EVAL: begin
          tot <= st.eval_total;
          idx <= '0;
          if (st.eval_total == '0) state <= S_IDLE;
          else                     state <= S_EMIT;
        end
        S_EMIT: begin
          if (cmd.emit) begin
            idx <= idx + 4'd1;
            if (cmd.emit_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // burst index stays inside the burst
  a_idx_in_burst: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (idx < tot))
    else $error("burst index ran past its count");

  // no empty burst is ever started
  a_burst_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (tot != '0))
    else $error("empty burst entered");

  // evaluation is never repeated back to back
  a_eval_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |=> (state != S_EVAL))
    else $error("evaluation repeated");

endmodule

// ===== rtl/core/sfr_datapath.sv =====
module sfr_datapath import sfr_pkg::*; #(
  parameter int HOLD_W = 8,
  parameter int REP_W  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            char_in,
  input  logic                  text_last,
  input  sfr_cmd_t              cmd,
  output sfr_status_t           st,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_char_valid,
  output logic                  out_run_last,
  output logic                  out_text_done
);

  // configuration
  logic [CNT_W-1:0]        search_len;
  logic [HOLD_W-1:0][7:0]  pat;
  logic [CNT_W-1:0]        replace_len;
  logic [REP_W-1:0][7:0]   rep;

  // window of held bytes plus the new byte
  logic [HOLD_W-1:0][7:0]  win;
  logic [CNT_W-1:0]        hc;
  logic                    last_q;

  // burst buffer
  logic [EMAX-1:0][7:0]    ebuf;
  logic                    bare_q;

  logic [EMAX-1:0][7:0]    win_pad;
  logic [EMAX-1:0][7:0]    pat_pad;
  logic [EMAX-1:0][7:0]    rep_pad;
  logic [EMAX-1:0][7:0]    win_sh;
  logic [EMAX-1:0][7:0]    ebuf_next;
  logic [CNT_W-1:0]        plen;
  logic [CNT_W-1:0]        rlen;
  logic [CNT_W-1:0]        n_cnt;
  logic [CNT_W-1:0]        rem;
  logic [CNT_W-1:0]        start;
  logic [CNT_W-1:0]        ecnt;
  logic [CNT_W-1:0]        hc_next;
  logic [EMAX:0]           cand;
  logic                    pfx_ok;
  logic                    full;
  logic                    use_rep;
  logic [7:0]              sel_byte;

  // effective lengths, saturated to what the hardware holds; search length 0 reads as 1
  always_comb begin
    if (search_len == '0)                         plen = 4'd1;
    else if (search_len > CNT_W'(HOLD_W))         plen = CNT_W'(HOLD_W);
    else                                          plen = search_len;
    if (replace_len > CNT_W'(REP_W))              rlen = CNT_W'(REP_W);
    else                                          rlen = replace_len;
  end

  // match evaluation over the window
  always_comb begin
    win_pad = 64'(win);
    pat_pad = 64'(pat);
    rep_pad = 64'(rep);
    n_cnt   = hc + 4'd1;

    // held bytes still a proper prefix of the pattern
    pfx_ok = (hc < plen);
    for (int j = 0; j < EMAX; j++) begin
      if ((CNT_W'(j) < hc) && (win_pad[j] != pat_pad[j])) pfx_ok = 1'b0;
    end

    // whole window equals the pattern
    full = (n_cnt == plen);
    for (int j = 0; j < EMAX; j++) begin
      if ((CNT_W'(j) < n_cnt) && (win_pad[j] != pat_pad[j])) full = 1'b0;
    end

    // each suffix of the window checked as a proper prefix
    rem = '0;
    for (int s = 0; s <= EMAX; s++) begin
      rem     = n_cnt - CNT_W'(s);
      cand[s] = (CNT_W'(s) <= n_cnt) && (rem < plen);
      for (int j = 0; j < EMAX; j++) begin
        if (s + j < EMAX) begin
          if ((CNT_W'(j) < rem) && (win_pad[s+j] != pat_pad[j])) cand[s] = 1'b0;
        end
      end
    end

    // leftmost surviving suffix
    start = CNT_W'(EMAX);
    for (int s = EMAX; s >= 0; s--) begin
      if (cand[s]) start = CNT_W'(s);
    end

    // what is released and what stays held
    use_rep = 1'b0;
    if (!pfx_ok) begin
      ecnt    = n_cnt;
      hc_next = '0;
    end else if (full) begin
      use_rep = 1'b1;
      ecnt    = rlen;
      hc_next = '0;
    end else if (last_q) begin
      ecnt    = n_cnt;
      hc_next = '0;
    end else begin
      ecnt    = start;
      hc_next = n_cnt - start;
    end

    ebuf_next = use_rep ? rep_pad : win_pad;
    win_sh    = win_pad >> {start, 3'b000};

    st.eval_total = (ecnt == '0 && last_q) ? 4'd1 : ecnt;
    st.slot_free  = !out_valid || out_ready;
  end

  // byte of the burst at the current index
  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < EMAX; i++) begin
      if (cmd.idx == IDX_W'(i)) sel_byte = ebuf[i];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_len  <= 4'd1;
      pat         <= '0;
      replace_len <= '0;
      rep         <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEARCH_LEN:    search_len  <= cfg_data[CNT_W-1:0];
        CFG_SEARCH_BYTES:  pat         <= cfg_data[HOLD_W*8-1:0];
        CFG_REPLACE_LEN:   replace_len <= cfg_data[CNT_W-1:0];
        CFG_REPLACE_BYTES: rep         <= cfg_data[REP_W*8-1:0];
        default: ;
      endcase
    end
  end

  // window, held count and burst buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      hc <= '0;
    end else if (cmd.eval) begin
      hc <= hc_next;
    end
    if (cmd.load) begin
      last_q <= text_last;
      for (int i = 0; i < HOLD_W; i++) begin
        if (hc == CNT_W'(i)) win[i] <= char_in;
      end
    end
    if (cmd.eval) begin
      win    <= win_sh[HOLD_W-1:0];
      ebuf   <= ebuf_next;
      bare_q <= (ecnt == '0) && last_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_char       <= bare_q ? 8'd0 : sel_byte;
      out_char_valid <= !bare_q;
      out_run_last   <= cmd.emit_last;
      out_text_done  <= cmd.emit_last && last_q;
    end
  end

  // held bytes always leave room for the incoming byte
  a_hold_room: assert property (@(posedge clk) disable iff (rst)
    hc < CNT_W'(HOLD_W))
    else $error("held count overflow");

  // a result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrote a pending result");

  // a burst never exceeds the buffer
  a_burst_size: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |-> (st.eval_total <= CNT_W'(EMAX)))
    else $error("burst larger than buffer");

endmodule

// ===== rtl/core/stream_find_and_replace.sv =====
// streaming find and replace over a byte text
// input stream: one text byte per request in s_axis_tdata, s_axis_tlast on the
// final byte of a text. output stream: one result per request; m_axis_tdata
// carries the byte and a run-last flag, m_axis_tuser says whether a byte is
// present, m_axis_tlast closes the text.
// configuration: cfg_index selects search length, search bytes, replace length
// or replace bytes; cfg_ready is always high. write only while the block is idle.
// each input byte is accepted, then evaluated by the single shared match evaluator,
// then its results are handed one at a time to the one output register; the first
// result is loaded from the emit state, which follows the evaluate state.
// bytes that may start a match are held back, up to search length minus one.
// reset clears the held bytes, the output register and the configuration
// (search length 1, empty replacement); no clearing pass is needed.
// when m_axis_tready is low the output register holds its result and the
// sequencer waits; a new byte is taken once the previous burst has been
// handed to the output register.
module stream_find_and_replace import sfr_pkg::*; #(
  parameter int MAX_SEARCH  = 8,
  parameter int MAX_REPLACE = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // text in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // char_in[7:0]
  input  logic                  s_axis_tlast,   // text_last
  // results out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // char_out[7:0], run_last[8], zero pad
  output logic                  m_axis_tuser,   // char_valid
  output logic                  m_axis_tlast    // text_done
);

  localparam int HOLD_W = (MAX_SEARCH < EMAX) ? MAX_SEARCH : EMAX;
  localparam int REP_W  = (MAX_REPLACE < EMAX) ? MAX_REPLACE : EMAX;

  sfr_cmd_t    cmd;
  sfr_status_t st;
  logic [7:0]  char_out;
  logic        run_last;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {7'd0, run_last, char_out};

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .HOLD_W (HOLD_W),
    .REP_W  (REP_W)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .char_in        (s_axis_tdata),
    .text_last      (s_axis_tlast),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_char       (char_out),
    .out_char_valid (m_axis_tuser),
    .out_run_last   (run_last),
    .out_text_done  (m_axis_tlast)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sfr_pkg::*;

  // one expected output request
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       run_end;
    logic       text_end;
  } out_req_t;

  typedef logic [7:0] window_t [9];

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // char_in[7:0]
  logic                  s_axis_tlast;   // text_last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [15:0]           m_axis_tdata;   // char_out[7:0], run_last[8], zero pad
  logic                  m_axis_tuser;   // char_valid
  logic                  m_axis_tlast;   // text_done

  // mirror of the block's registers and hold buffer
  logic [3:0]  pat_len_reg;
  logic [63:0] pat_reg;
  logic [3:0]  rep_len_reg;
  logic [63:0] rep_reg;
  logic [7:0]  held_text [8];
  int          held_n;

  out_req_t pending_out [$];
  int       errors;
  bit       quiet;
  int       stall_left;

  stream_find_and_replace u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // effective pattern length, 0 reads as 1, saturates at 8
  function automatic int pattern_len();
    int n;
    n = int'(pat_len_reg);
    if (n < 1) n = 1;
    if (n > 8) n = 8;
    return n;
  endfunction

  function automatic int replacement_len();
    int n;
    n = int'(rep_len_reg);
    if (n > 8) n = 8;
    return n;
  endfunction

  // true when w[off .. off+len) is a proper prefix of the pattern
  function automatic bit is_pattern_prefix(input window_t w, input int off, input int len,
                                           input int plen);
    int i;
    if (len >= plen) return 1'b0;
    for (i = 0; i < len; i++)
      if (w[off + i] != pat_reg[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // work out the output requests caused by one text byte
  function automatic void replace_step(input logic [7:0] c, input logic last);
    window_t    w;
    out_req_t   burst [$];
    int         plen, n, start, i;
    plen = pattern_len();
    for (i = 0; i < held_n; i++) w[i] = held_text[i];
    w[held_n] = c;
    n = held_n + 1;
    if (!is_pattern_prefix(w, 0, held_n, plen)) begin
      // pattern changed under the held bytes: release everything unchanged
      for (i = 0; i < n; i++) burst.push_back('{w[i], 1'b1, 1'b0, 1'b0});
      n = 0;
    end else if (n == plen && w[held_n] == pat_reg[8*held_n +: 8]) begin
      for (i = 0; i < replacement_len(); i++)
        burst.push_back('{rep_reg[8*i +: 8], 1'b1, 1'b0, 1'b0});
      n = 0;
    end else begin
      // drop bytes from the front until the rest can still start a match
      start = 0;
      while (start < n && !is_pattern_prefix(w, start, n - start, plen)) begin
        burst.push_back('{w[start], 1'b1, 1'b0, 1'b0});
        start++;
      end
      for (i = 0; i < n - start; i++) w[i] = w[i + start];
      n -= start;
    end
    if (last) begin
      for (i = 0; i < n; i++) burst.push_back('{w[i], 1'b1, 1'b0, 1'b0});
      n = 0;
    end
    for (i = 0; i < n; i++) held_text[i] = w[i];
    held_n = n;
    if (last) begin
      if (burst.size() == 0) burst.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
      burst[burst.size() - 1].text_end = 1'b1;
    end
    if (burst.size() > 0) burst[burst.size() - 1].run_end = 1'b1;
    foreach (burst[i]) pending_out.push_back(burst[i]);
  endfunction

  // idle gap length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sink side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      m_axis_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each output request with the oldest expectation
  always @(posedge clk) begin
    out_req_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected output: expected none, actual char %h valid %b last %b done %b",
                 $time, m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[8], m_axis_tlast);
        errors++;
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata[7:0] !== want.ch) begin
          $display("%0t: char_out: expected %h actual %h", $time, want.ch, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tuser !== want.has_char) begin
          $display("%0t: char_valid: expected %b actual %b", $time, want.has_char,
                   m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[8] !== want.run_end) begin
          $display("%0t: run_last: expected %b actual %b", $time, want.run_end,
                   m_axis_tdata[8]);
          errors++;
        end
        if (m_axis_tlast !== want.text_end) begin
          $display("%0t: text_done: expected %b actual %b", $time, want.text_end,
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // send one text byte, entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    replace_step(c, last);
    @(negedge clk);
  endtask

  // stop sending and wait until every expected request has come
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_out.size() != 0) @(negedge clk);
  endtask

  // idle point for register writes: a byte with no output may still be in flight
  task automatic wait_idle();
    drain();
    repeat (10) @(negedge clk);
  endtask

  // one register write, after which cfg_valid is dropped again
  task automatic write_reg(input sfr_cfg_idx_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SEARCH_LEN:    pat_len_reg = value[3:0];
      CFG_SEARCH_BYTES:  pat_reg     = value;
      CFG_REPLACE_LEN:   rep_len_reg = value[3:0];
      CFG_REPLACE_BYTES: rep_reg     = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // reset settings: a single zero byte is deleted; then length 0 taken as 1
  task automatic test_reset_settings();
    wait_idle();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    wait_idle();
    write_reg(CFG_SEARCH_LEN, 64'd0);
    write_reg(CFG_SEARCH_BYTES, 64'hff);
    send_char(8'hff, 1'b1);
  endtask

  // short pattern, partial match released, replacement longer than pattern
  task automatic test_short_pattern();
    wait_idle();
    write_reg(CFG_SEARCH_LEN, 64'd2);
    write_reg(CFG_SEARCH_BYTES, 64'h6261);
    write_reg(CFG_REPLACE_LEN, 64'd3);
    write_reg(CFG_REPLACE_BYTES, 64'h5a5958);
    send_char("a", 1'b0);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char("x", 1'b0);
    send_char("b", 1'b1);
  endtask

  // full-width pattern and replacement, lengths above 8 saturate
  task automatic test_full_width();
    logic [63:0] pat;
    int i;
    pat = 64'hfe01_7f80_00ff_00ff;
    wait_idle();
    write_reg(CFG_SEARCH_LEN, 64'd15);
    write_reg(CFG_SEARCH_BYTES, pat);
    write_reg(CFG_REPLACE_LEN, 64'd15);
    write_reg(CFG_REPLACE_BYTES, 64'h0123_4567_89ab_cdef);
    for (i = 0; i < 8; i++) send_char(pat[8*i +: 8], i == 7);
  endtask

  // pattern registers change while bytes are held
  task automatic test_pattern_change_midtext();
    wait_idle();
    write_reg(CFG_SEARCH_LEN, 64'd4);
    write_reg(CFG_SEARCH_BYTES, 64'h64636261);
    write_reg(CFG_REPLACE_LEN, 64'd1);
    write_reg(CFG_REPLACE_BYTES, 64'h2a);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    wait_idle();
    write_reg(CFG_SEARCH_BYTES, 64'h7a7978);
    send_char("q", 1'b1);
    wait_idle();
    write_reg(CFG_SEARCH_BYTES, 64'h64636261);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char("c", 1'b0);
    wait_idle();
    // held bytes now longer than the pattern
    write_reg(CFG_SEARCH_LEN, 64'd2);
    send_char("x", 1'b1);
  endtask

  // random settings and texts built mostly from pattern pieces
  task automatic test_random_texts();
    logic [7:0]  alpha [3];
    logic [7:0]  text_q [$];
    logic [63:0] word;
    int          phase, sent, tlen, plen, cut, i, j, r;
    for (phase = 0; phase < 6; phase++) begin
      wait_idle();
      quiet = ($urandom_range(0, 3) == 0);
      for (i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(0, 255));
      for (i = 0; i < 8; i++) word[8*i +: 8] = alpha[$urandom_range(0, 2)];
      r = $urandom_range(0, 9);
      write_reg(CFG_SEARCH_LEN, (r == 0) ? 64'd0 : (r == 1) ? 64'd15 : (r == 2) ? 64'd8 :
                                64'($urandom_range(1, 4)));
      write_reg(CFG_SEARCH_BYTES, word);
      r = $urandom_range(0, 9);
      write_reg(CFG_REPLACE_LEN, (r == 0) ? 64'd0 : (r == 1) ? 64'($urandom_range(9, 15)) :
                                 64'($urandom_range(0, 8)));
      write_reg(CFG_REPLACE_BYTES, {$urandom(), $urandom()});
      plen = pattern_len();
      sent = 0;
      // the last text of a phase may be cut short and resumed under new settings
      while (sent < 25) begin
        text_q.delete();
        tlen = $urandom_range(1, 16);
        while (text_q.size() < tlen) begin
          r = $urandom_range(0, 99);
          if (r < 35) begin
            for (i = 0; i < plen; i++) text_q.push_back(pat_reg[8*i +: 8]);
          end else if (r < 50 && plen > 1) begin
            cut = $urandom_range(1, plen - 1);
            for (i = 0; i < cut; i++) text_q.push_back(pat_reg[8*i +: 8]);
          end else if (r < 80) begin
            text_q.push_back(pat_reg[8*$urandom_range(0, plen - 1) +: 8]);
          end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        for (j = 0; j < text_q.size() && sent < 25; j++) begin
          send_char(text_q[j], j == text_q.size() - 1);
          sent++;
          if ($urandom_range(0, 29) == 0) drain();
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SEARCH_LEN;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    quiet         = 1'b0;
    errors        = 0;
    pat_len_reg   = 4'd1;
    pat_reg       = '0;
    rep_len_reg   = 4'd0;
    rep_reg       = '0;
    held_n        = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_settings();
    test_short_pattern();
    test_full_width();
    test_pattern_change_midtext();
    test_random_texts();

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("stream_find_and_replace: match");
    end else begin
      $display("stream_find_and_replace: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("stream_find_and_replace: mismatch");
    $finish;
  end

endmodule
